// ===== rtl/kdw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kdw_pkg;

   localparam int COORD_W     = 32;
   localparam int BLOCK_W     = 31;
   localparam int PASS_W      = 7;
   localparam int CSR_IDX_W   = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // The walk is over once more than this many root restarts have been seen.
   localparam logic [PASS_W-1:0] PASS_LIMIT = 7'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROOT_LEFT   = 4'd0,
      CSR_ROOT_TOP    = 4'd1,
      CSR_ROOT_RIGHT  = 4'd2,
      CSR_ROOT_BOTTOM = 4'd3,
      CSR_SEL_LEFT    = 4'd4,
      CSR_SEL_TOP     = 4'd5,
      CSR_SEL_RIGHT   = 4'd6,
      CSR_SEL_BOTTOM  = 4'd7
   } csr_idx_type;

   typedef enum logic {
      OP_LEAF  = 1'b0,
      OP_SPLIT = 1'b1
   } op_type;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
   } rect_type;

   typedef struct packed {
      logic               has_block;
      logic [BLOCK_W-1:0] block_id;
      op_type             op;
      logic [COORD_W-1:0] coord;
      logic [COORD_W-1:0] above;
   } cmd_type;

   typedef struct packed {
      logic                 valid;
      logic [CSR_IDX_W-1:0] index;
      logic [COORD_W-1:0]   data;
   } csr_wr_type;

   typedef struct packed {
      logic full;
      logic valid;
   } q_stat_type;

endpackage

`default_nettype wire

// ===== rtl/kd_index_range_walker.sv =====
// Range query walker for a kd-tree index stored in pre-order.
//
// Input channel (req_*): one beat per index entry, carrying whether the entry
// names a data block, its block id, whether it carries a split and the split
// coordinate. A beat is taken on a rising edge with req_valid high and
// req_stall low. Result channel (rsp_*): exactly one beat per entry, in order,
// with the hit flag, the hit block id (zero without a hit), the sticky done
// flag and the stack overflow flag. The receiver holds rsp_stall high to stop
// it; the beat then stays on the ports unchanged.
// Configuration channel (csr_*): writes the root cell and the selection
// rectangle by index. csr_ready is always high; write only while no beat is
// in flight. Unknown indexes are ignored.
// Throughput is one entry per cycle while rsp_stall does not hold the
// result, set by the single execute stage that updates the current cell and
// the stack together. A four entry queue between the intake stage and the
// execute stage absorbs stalls.
// Synchronous reset clears the walk, the stack pointer, the pass counter and
// all configuration registers to zero; no beat is pending afterward.
`timescale 1ns / 1ps
`default_nettype none

module kd_index_range_walker #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_has_block,
   input  wire logic [30:0]                 req_block_id,
   input  wire logic                        req_has_split,
   input  wire logic signed [31:0]          req_split_coord,

   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_hit,
   output logic [30:0]                      rsp_hit_block,
   output logic                             rsp_done_res,
   output logic                             rsp_overflow,

   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [3:0]                  csr_index,
   input  wire logic [31:0]                 csr_data
);

   kdw_pkg::q_stat_type q_stat;
   kdw_pkg::cmd_type    q_in_cmd;
   kdw_pkg::cmd_type    q_head;
   kdw_pkg::csr_wr_type csr_wr;
   logic                q_push;
   logic                q_pop;

   // Register writes go straight into the execute stage, so the port never waits.
   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   // Intake stage: takes the beat and precomputes the upper split bound.
   kdw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_has_block   (req_has_block),
      .req_block_id    (req_block_id),
      .req_has_split   (req_has_split),
      .req_split_coord (req_split_coord),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_cmd           (q_in_cmd)
   );

   kdw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in_cmd),
      .pop      (q_pop),
      .head_cmd (q_head),
      .stat     (q_stat)
   );

   // Execute stage: overlap test, split/push, pop or restart, result register.
   kdw_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_wr        (csr_wr),
      .q_stat        (q_stat),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hit       (rsp_hit),
      .rsp_hit_block (rsp_hit_block),
      .rsp_done_res  (rsp_done_res),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

`default_nettype wire

// ===== rtl/kdw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdw_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_has_block,
   input  wire logic [kdw_pkg::BLOCK_W-1:0] req_block_id,
   input  wire logic                       req_has_split,
   input  wire logic signed [kdw_pkg::COORD_W-1:0] req_split_coord,
   input  wire kdw_pkg::q_stat_type        q_stat,
   output logic                            q_push,
   output kdw_pkg::cmd_type                q_cmd
);

   logic             fr_vld_ff, fr_vld_in;
   kdw_pkg::cmd_type fr_cmd_ff, fr_cmd_in;
   logic             fr_load;

   // The stage holds while its entry cannot enter the full queue.
   assign req_stall = fr_vld_ff && q_stat.full;
   assign fr_load   = req_valid && !req_stall;
   assign q_push    = fr_vld_ff && !q_stat.full;
   assign q_cmd     = fr_cmd_ff;

   always_comb begin
      fr_vld_in = fr_load || (fr_vld_ff && q_stat.full);
      fr_cmd_in = fr_cmd_ff;
      if (fr_load) begin
         fr_cmd_in.has_block = req_has_block;
         fr_cmd_in.block_id  = req_block_id;
         fr_cmd_in.op        = req_has_split ? kdw_pkg::OP_SPLIT : kdw_pkg::OP_LEAF;
         fr_cmd_in.coord     = req_split_coord;
         // Lower bound of the upper half; wraps at the top of the range.
         fr_cmd_in.above     = req_split_coord + 32'sd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_vld_ff <= 1'b0;
      end else begin
         fr_vld_ff <= fr_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      fr_cmd_ff <= fr_cmd_in;
   end

endmodule

`default_nettype wire

// ===== rtl/kdw_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdw_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire kdw_pkg::cmd_type push_cmd,
   input  wire logic         pop,
   output kdw_pkg::cmd_type  head_cmd,
   output kdw_pkg::q_stat_type stat
);

   localparam int CNT_W = $clog2(kdw_pkg::QUEUE_DEPTH + 1);

   kdw_pkg::cmd_type              slot_ff [kdw_pkg::QUEUE_DEPTH];
   logic [kdw_pkg::QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [kdw_pkg::QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]              count_ff, count_in;

   assign stat.full  = (count_ff == CNT_W'(kdw_pkg::QUEUE_DEPTH));
   assign stat.valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/kdw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdw_back #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire kdw_pkg::csr_wr_type         csr_wr,
   input  wire kdw_pkg::q_stat_type         q_stat,
   input  wire kdw_pkg::cmd_type            q_head,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_hit,
   output logic [kdw_pkg::BLOCK_W-1:0]      rsp_hit_block,
   output logic                             rsp_done_res,
   output logic                             rsp_overflow
);

   localparam int PTR_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(STACK_DEPTH);

   kdw_pkg::rect_type root_ff, root_in;
   kdw_pkg::rect_type sel_ff, sel_in;
   kdw_pkg::rect_type cur_ff, cur_in;
   kdw_pkg::rect_type tos_ff;
   kdw_pkg::rect_type push_rect;
   kdw_pkg::rect_type stk_mem [STACK_DEPTH];

   logic [PTR_W-1:0]           ptr_ff, ptr_in, ptr_dec;
   logic [IDX_W-1:0]           rd_idx;
   logic [kdw_pkg::PASS_W-1:0] pass_ff, pass_in;
   logic                       finished_ff, finished_in;
   logic                       fresh_ff, fresh_in;
   logic                       push_en;

   logic                       out_vld_ff, out_vld_in;
   logic                       out_hit_ff, out_hit_in;
   logic [kdw_pkg::BLOCK_W-1:0] out_blk_ff, out_blk_in;
   logic                       out_done_ff, out_done_in;
   logic                       out_ovf_ff, out_ovf_in;

   logic                       go;
   logic                       overlap;
   logic                       wider;
   logic signed [kdw_pkg::COORD_W:0] width_s, height_s;

   assign go    = q_stat.valid && (!out_vld_ff || !rsp_stall);
   assign q_pop = go;

   assign rsp_valid     = out_vld_ff;
   assign rsp_hit       = out_hit_ff;
   assign rsp_hit_block = out_blk_ff;
   assign rsp_done_res  = out_done_ff;
   assign rsp_overflow  = out_ovf_ff;

   // Inclusive overlap of the current cell with the selection.
   assign overlap = !($signed(sel_ff.left)   > $signed(cur_ff.right))  &&
                    !($signed(sel_ff.right)  < $signed(cur_ff.left))   &&
                    !($signed(sel_ff.top)    < $signed(cur_ff.bottom)) &&
                    !($signed(sel_ff.bottom) > $signed(cur_ff.top));

   assign width_s  = $signed({cur_ff.right[kdw_pkg::COORD_W-1], cur_ff.right}) -
                     $signed({cur_ff.left[kdw_pkg::COORD_W-1], cur_ff.left});
   assign height_s = $signed({cur_ff.top[kdw_pkg::COORD_W-1], cur_ff.top}) -
                     $signed({cur_ff.bottom[kdw_pkg::COORD_W-1], cur_ff.bottom});
   assign wider    = width_s > height_s;

   always_comb begin
      root_in     = root_ff;
      sel_in      = sel_ff;
      cur_in      = cur_ff;
      ptr_in      = ptr_ff;
      pass_in     = pass_ff;
      finished_in = finished_ff;
      fresh_in    = fresh_ff;
      push_en     = 1'b0;
      push_rect   = cur_ff;
      out_vld_in  = out_vld_ff && rsp_stall;
      out_hit_in  = out_hit_ff;
      out_blk_in  = out_blk_ff;
      out_done_in = out_done_ff;
      out_ovf_in  = out_ovf_ff;

      if (csr_wr.valid) begin
         case (kdw_pkg::csr_idx_type'(csr_wr.index))
            kdw_pkg::CSR_ROOT_LEFT: begin
               root_in.left = csr_wr.data;
               if (fresh_ff) cur_in.left = csr_wr.data;
            end
            kdw_pkg::CSR_ROOT_TOP: begin
               root_in.top = csr_wr.data;
               if (fresh_ff) cur_in.top = csr_wr.data;
            end
            kdw_pkg::CSR_ROOT_RIGHT: begin
               root_in.right = csr_wr.data;
               if (fresh_ff) cur_in.right = csr_wr.data;
            end
            kdw_pkg::CSR_ROOT_BOTTOM: begin
               root_in.bottom = csr_wr.data;
               if (fresh_ff) cur_in.bottom = csr_wr.data;
            end
            kdw_pkg::CSR_SEL_LEFT:   sel_in.left   = csr_wr.data;
            kdw_pkg::CSR_SEL_TOP:    sel_in.top    = csr_wr.data;
            kdw_pkg::CSR_SEL_RIGHT:  sel_in.right  = csr_wr.data;
            kdw_pkg::CSR_SEL_BOTTOM: sel_in.bottom = csr_wr.data;
            default: ;
         endcase
      end

      if (go) begin
         out_vld_in  = 1'b1;
         out_hit_in  = 1'b0;
         out_ovf_in  = 1'b0;
         out_done_in = 1'b1;
         if (!finished_ff) begin
            fresh_in   = 1'b0;
            out_hit_in = q_head.has_block && overlap;
            case (q_head.op)
               kdw_pkg::OP_SPLIT: begin
                  if (ptr_ff == PTR_W'(STACK_DEPTH)) begin
                     out_ovf_in = 1'b1;
                  end else begin
                     // Low half stays current, high half goes on the stack.
                     push_en = 1'b1;
                     if (wider) begin
                        cur_in.right   = q_head.coord;
                        push_rect.left = q_head.above;
                     end else begin
                        cur_in.top       = q_head.coord;
                        push_rect.bottom = q_head.above;
                     end
                     ptr_in = ptr_ff + 1'b1;
                  end
               end
               kdw_pkg::OP_LEAF: begin
                  if (ptr_ff != '0) begin
                     cur_in = tos_ff;
                     ptr_in = ptr_ff - 1'b1;
                  end else begin
                     cur_in = root_ff;
                     if (pass_ff <= kdw_pkg::PASS_LIMIT) begin
                        pass_in = pass_ff + 1'b1;
                     end
                     if (pass_in > kdw_pkg::PASS_LIMIT) begin
                        finished_in = 1'b1;
                        out_hit_in  = 1'b0;
                     end
                  end
               end
               default: ;
            endcase
            out_done_in = finished_in;
         end
         out_blk_in = out_hit_in ? q_head.block_id : '0;
      end

      ptr_dec = ptr_in - 1'b1;
      rd_idx  = (ptr_in == '0) ? '0 : ptr_dec[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff     <= '0;
         sel_ff      <= '0;
         cur_ff      <= '0;
         ptr_ff      <= '0;
         pass_ff     <= '0;
         finished_ff <= 1'b0;
         fresh_ff    <= 1'b1;
         out_vld_ff  <= 1'b0;
      end else begin
         root_ff     <= root_in;
         sel_ff      <= sel_in;
         cur_ff      <= cur_in;
         ptr_ff      <= ptr_in;
         pass_ff     <= pass_in;
         finished_ff <= finished_in;
         fresh_ff    <= fresh_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_hit_ff  <= out_hit_in;
      out_blk_ff  <= out_blk_in;
      out_done_ff <= out_done_in;
      out_ovf_ff  <= out_ovf_in;
   end

   // Stack memory. The top entry is read ahead into tos_ff, with the
   // entry being pushed forwarded so a pop may follow a push directly.
   always_ff @(posedge clock) begin
      if (push_en) begin
         stk_mem[ptr_ff[IDX_W-1:0]] <= push_rect;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         tos_ff <= push_rect;
      end else begin
         tos_ff <= stk_mem[rd_idx];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/kdw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdw_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_hit,
   input wire logic [30:0] rsp_hit_block,
   input wire logic        rsp_done_res,
   input wire logic        rsp_overflow
);

   // A stalled result beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_blk_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_block == 31'd0)
      else $error("block id reported without a hit");

   // Once done, a beat carries neither a hit nor an overflow.
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_hit && !rsp_overflow)
      else $error("hit or overflow reported with done");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind kd_index_range_walker kdw_checker u_kdw_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_hit       (rsp_hit),
   .rsp_hit_block (rsp_hit_block),
   .rsp_done_res  (rsp_done_res),
   .rsp_overflow  (rsp_overflow)
);

`default_nettype wire
